[sv/bsc_pkg.sv]
// Package for the byte stream cipher: payload structs, sequencer states,
// register indexes and AES table and round helpers. No dependencies.
package bsc_pkg;

  localparam int unsigned KEY_BYTES = 16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       result_last;
  } out_t;

  typedef logic [15:0][7:0] blk_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SINGLE, ST_KEYX, ST_START, ST_ROUND, ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    REG_MODE = 3'd0, REG_DIR = 3'd1, REG_KLEN = 3'd2, REG_KLOW = 3'd3, REG_KHIGH = 3'd4
  } reg_e;

  localparam logic [1:0] MODE_XOR = 2'd1;
  localparam logic [1:0] MODE_AES = 2'd2;

  localparam logic [2047:0] SBOX_VEC = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [2047:0] INV_SBOX_VEC = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] sbox(input logic [7:0] v);
    return SBOX_VEC[{~v, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] v);
    return INV_SBOX_VEC[{~v, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd0: r = 8'h01;
      4'd1: r = 8'h02;
      4'd2: r = 8'h04;
      4'd3: r = 8'h08;
      4'd4: r = 8'h10;
      4'd5: r = 8'h20;
      4'd6: r = 8'h40;
      4'd7: r = 8'h80;
      4'd8: r = 8'h1b;
      4'd9: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] m);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (m[i]) p = p ^ x;
      x = xtime(x);
    end
    return p;
  endfunction

  function automatic blk_t shift_rows(input blk_t s, input logic inverse);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inverse) t[c*4+r] = s[((c + 4 - r) % 4)*4 + r];
        else         t[c*4+r] = s[((c + r) % 4)*4 + r];
      end
    end
    return t;
  endfunction

  function automatic blk_t mix_columns(input blk_t s, input logic inverse);
    blk_t t;
    logic [3:0] m0, m1, m2, m3;
    logic [7:0] a0, a1, a2, a3;
    m0 = inverse ? 4'd14 : 4'd2;
    m1 = inverse ? 4'd11 : 4'd3;
    m2 = inverse ? 4'd13 : 4'd1;
    m3 = inverse ? 4'd9  : 4'd1;
    for (int c = 0; c < 4; c++) begin
      a0 = s[c*4];
      a1 = s[c*4+1];
      a2 = s[c*4+2];
      a3 = s[c*4+3];
      t[c*4]   = gmul(a0, m0) ^ gmul(a1, m1) ^ gmul(a2, m2) ^ gmul(a3, m3);
      t[c*4+1] = gmul(a0, m3) ^ gmul(a1, m0) ^ gmul(a2, m1) ^ gmul(a3, m2);
      t[c*4+2] = gmul(a0, m2) ^ gmul(a1, m3) ^ gmul(a2, m0) ^ gmul(a3, m1);
      t[c*4+3] = gmul(a0, m1) ^ gmul(a1, m2) ^ gmul(a2, m3) ^ gmul(a3, m0);
    end
    return t;
  endfunction

  // g() of the key schedule applied to the last word of a round key
  function automatic logic [31:0] key_g(input logic [31:0] w, input logic [7:0] rc);
    return {sbox(w[7:0]), sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]) ^ rc};
  endfunction

  function automatic blk_t key_fwd(input blk_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3;
    w0 = k[3:0] ^ key_g(k[15:12], rc);
    w1 = k[7:4] ^ w0;
    w2 = k[11:8] ^ w1;
    w3 = k[15:12] ^ w2;
    return {w3, w2, w1, w0};
  endfunction

  function automatic blk_t key_inv(input blk_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3;
    w3 = k[15:12] ^ k[11:8];
    w2 = k[11:8] ^ k[7:4];
    w1 = k[7:4] ^ k[3:0];
    w0 = k[3:0] ^ key_g(w3, rc);
    return {w3, w2, w1, w0};
  endfunction

endpackage

[sv/byte_stream_cipher_xor_aes.sv]
// Byte stream cipher top level: pass through, repeating-key XOR, AES-128 ECB.
// Depends on bsc_pkg (payload types, tables, round helpers).
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+----------------------------------
//  in      | in  | in_valid_i / in_ready_o | in_i  (data_byte, is_last)
//  out     | out | out_valid_o/out_ready_i | out_o (result_byte, result_last)
//  cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Pass through and XOR: one transaction in, one out; the single output holding
// stage must empty before the next byte is taken.
// AES: bytes 1..15 of a block are taken one per cycle; the closing byte starts
// the shared round unit: a load step, then 10 rounds (after forward key
// expansion when decrypting), then 16 output transactions, one per cycle unless stalled.
// Reset clears control state and registers; the block store holds no reset.
// Output stalls hold the current byte; no input is taken until all output
// bytes of the previous transaction have gone.
module byte_stream_cipher_xor_aes
  import bsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  state_e      state_q, state_d;
  logic [1:0]  mode_q, mode_d;
  logic        dir_q, dir_d;
  logic [4:0]  klen_q, klen_d;
  logic [63:0] klow_q, klow_d, khigh_q, khigh_d;
  logic [3:0]  pos_q, pos_d;
  logic [3:0]  fill_q, fill_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        last_q, last_d;
  logic [7:0]  obyte_q, obyte_d;
  logic        olast_q, olast_d;
  blk_t        st_q, st_d;   // gather buffer, AES state and output shifter
  blk_t        rk_q, rk_d;   // current round key

  logic        in_acc, out_acc, cfg_acc;
  logic [4:0]  eff_len;
  blk_t        key_full, key_pad, nk, pk, tmp;
  logic [7:0]  xbyte;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_SINGLE) || (state_q == ST_EMIT);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;

  assign eff_len  = (klen_q > 5'(KEY_BYTES)) ? 5'(KEY_BYTES) : klen_q;
  assign key_full = {khigh_q, klow_q};

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      key_pad[i] = (5'(i) < eff_len) ? key_full[i] : 8'h00;
    end
  end

  always_comb begin
    if (state_q == ST_SINGLE) begin
      out_o.result_byte = obyte_q;
      out_o.result_last = olast_q;
    end else begin
      out_o.result_byte = st_q[0];
      out_o.result_last = last_q && (cnt_q == 4'd15);
    end
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    dir_d   = dir_q;
    klen_d  = klen_q;
    klow_d  = klow_q;
    khigh_d = khigh_q;
    pos_d   = pos_q;
    fill_d  = fill_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    obyte_d = obyte_q;
    olast_d = olast_q;
    st_d    = st_q;
    rk_d    = rk_q;
    nk      = key_fwd(rk_q, rcon(cnt_q));
    pk      = key_inv(rk_q, rcon(4'd9 - cnt_q));
    tmp     = st_q;
    xbyte   = in_i.data_byte;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (mode_q == MODE_AES) begin
            // first byte of a block zeroes the rest, which pads a short block
            if (fill_q == 4'd0) st_d = '0;
            st_d[fill_q] = in_i.data_byte;
            if (fill_q == 4'd15 || in_i.is_last) begin
              fill_d  = 4'd0;
              last_d  = in_i.is_last;
              rk_d    = key_pad;
              cnt_d   = 4'd0;
              state_d = dir_q ? ST_KEYX : ST_START;
            end else begin
              fill_d = fill_q + 4'd1;
            end
          end else begin
            if (mode_q == MODE_XOR && eff_len != 5'd0) begin
              xbyte = in_i.data_byte ^ key_full[pos_q];
              pos_d = (({1'b0, pos_q} + 5'd1) >= eff_len) ? 4'd0 : pos_q + 4'd1;
            end
            obyte_d = xbyte;
            olast_d = in_i.is_last;
            state_d = ST_SINGLE;
          end
        end
      end
      ST_SINGLE: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      ST_KEYX: begin
        // walk the schedule forward to the last round key
        rk_d  = nk;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd9) begin
          cnt_d   = 4'd0;
          state_d = ST_START;
        end
      end
      ST_START: begin
        st_d    = st_q ^ rk_q;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (!dir_q) begin
          for (int i = 0; i < 16; i++) tmp[i] = sbox(st_q[i]);
          tmp = shift_rows(tmp, 1'b0);
          if (cnt_q != 4'd9) tmp = mix_columns(tmp, 1'b0);
          st_d = tmp ^ nk;
          rk_d = nk;
        end else begin
          tmp = shift_rows(st_q, 1'b1);
          for (int i = 0; i < 16; i++) tmp[i] = inv_sbox(tmp[i]);
          tmp = tmp ^ pk;
          if (cnt_q != 4'd9) tmp = mix_columns(tmp, 1'b1);
          st_d = tmp;
          rk_d = pk;
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd9) begin
          cnt_d   = 4'd0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          st_d  = st_q >> 8;
          cnt_d = cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            cnt_d   = 4'd0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // any write to a known register restarts key position and gathering
    if (cfg_acc) begin
      unique case (cfg_index_i)
        REG_MODE:  mode_d  = cfg_data_i[1:0];
        REG_DIR:   dir_d   = cfg_data_i[0];
        REG_KLEN:  klen_d  = cfg_data_i[4:0];
        REG_KLOW:  klow_d  = cfg_data_i;
        REG_KHIGH: khigh_d = cfg_data_i;
        default: ;
      endcase
      if (cfg_index_i <= REG_KHIGH) begin
        pos_d  = 4'd0;
        fill_d = 4'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= '0;
      dir_q   <= 1'b0;
      klen_q  <= '0;
      klow_q  <= '0;
      khigh_q <= '0;
      pos_q   <= '0;
      fill_q  <= '0;
      cnt_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      dir_q   <= dir_d;
      klen_q  <= klen_d;
      klow_q  <= klow_d;
      khigh_q <= khigh_d;
      pos_q   <= pos_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    st_q    <= st_d;
    rk_q    <= rk_d;
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while output pending");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_acc && cfg_index_i <= REG_KHIGH) |=> (fill_q == 4'd0 && pos_q == 4'd0))
    else $error("config write did not clear position");

  a_emit_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_acc && cnt_q == 4'd15) |=> (state_q == ST_IDLE))
    else $error("block emit did not finish");

  a_round_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (cnt_q <= 4'd9))
    else $error("round counter overran");

endmodule
